// ===== rtl/mmc4_pkg.sv =====
package mmc4_pkg;

  // byte arithmetic widths
  localparam int unsigned DataW = 8;
  localparam int unsigned ModW  = DataW + 1;  // wide enough for twice the character count
  localparam int unsigned CntW  = $clog2(DataW);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_PRG_COUNT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_COUNT = 8'd1;

  // cpu write decode on address bits 15..12
  localparam logic [3:0] NIB_PRG      = 4'hA;
  localparam logic [3:0] NIB_CHR_FIRST = 4'hB;
  localparam logic [3:0] NIB_CHR_LAST  = 4'hE;
  localparam logic [3:0] NIB_MIR      = 4'hF;

  // ppu trigger keys, address bits 13..4
  localparam logic [9:0] KEY_T0_LOW  = 10'h0FD;
  localparam logic [9:0] KEY_T0_HIGH = 10'h0FE;
  localparam logic [9:0] KEY_T1_LOW  = 10'h1FD;
  localparam logic [9:0] KEY_T1_HIGH = 10'h1FE;

  // reset value of the upper pattern table base
  localparam logic [DataW-1:0] HIGH_BASE_RST = 8'd4;

  typedef logic [DataW-1:0] byte_t;
  typedef logic [ModW-1:0]  mod_t;

endpackage

// ===== rtl/mmc4_mod_unit.sv =====
module mmc4_mod_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mmc4_pkg::byte_t dividend_i,
  input  mmc4_pkg::mod_t  modulus_i,
  output logic          done_o,
  output mmc4_pkg::mod_t  rem_o
);
  import mmc4_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  mod_t             rem_q, rem_d;
  mod_t             mod_q, mod_d;
  byte_t            shf_q, shf_d;
  logic [ModW:0]    trial;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, shf_q[DataW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    mod_d  = mod_q;
    shf_d  = shf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      mod_d  = modulus_i;
      shf_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, mod_q}) begin
        rem_d = ModW'(trial - {1'b0, mod_q});
      end else begin
        rem_d = trial[ModW-1:0];
      end
      shf_d = {shf_q[DataW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    mod_q <= mod_d;
    shf_q <= shf_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("mod unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished run");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) && mod_q != '0 |-> rem_q < mod_q)
    else $error("partial remainder not below modulus");

endmodule

// ===== rtl/mmc4_bank_latch_mapper.sv =====
// mmc4 bank mapper with pattern fetch latches
//
// input channel: one word per bus event, mode/address/write_data, taken when
// in_valid_i is high and in_stall_o is low. mode 0 is a cpu register write,
// mode 1 a ppu pattern fetch address.
// output channel: one word per input word carrying the mapping after that
// event (prg_page, chr_low_page, chr_high_page, mirror_select, chr_changed),
// taken when out_valid_o is high and out_stall_i is low.
// config channel: cfg_index_i 0 = program 16k count, 1 = character 8k count,
// written when cfg_valid_i and cfg_ready_o are high; other indexes ignored.
// program and character bank writes run an 8 step restoring
// modulo through the shared remainder unit and wait in the calc state for it;
// mirroring writes, other writes and ppu fetches go straight to the finish state.
// one word is in flight at a time, so a new word is not accepted until the
// previous one has been moved into the output register.
// a finished word waits in the output register; while out_stall_i is high
// the next word is still accepted and computed, then held until the output
// register frees up.
// reset: counts 1 and 0, all banks 0, both latches in the fe state, upper
// table base 4, mirroring 0, no output pending.
module mmc4_bank_latch_mapper (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [15:0]              address_i,
  input  mmc4_pkg::byte_t          write_data_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mmc4_pkg::byte_t          prg_page_o,
  output mmc4_pkg::byte_t          chr_low_page_o,
  output mmc4_pkg::byte_t          chr_high_page_o,
  output logic                     mirror_select_o,
  output logic                     chr_changed_o,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [mmc4_pkg::CfgIdxW-1:0] cfg_index_i,
  input  mmc4_pkg::byte_t          cfg_data_i
);
  import mmc4_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_e;

  state_e      state_q, state_d;

  // configuration
  byte_t       prg_cnt_q, chr_cnt_q;

  // captured word
  logic        mode_q;
  logic [15:0] addr_q;
  byte_t       data_q;

  // mapping state
  byte_t       prg_base_q, prg_base_d;
  byte_t       chr_bank_q [4];
  byte_t       chr_bank_d [4];
  logic [1:0]  lat_hi_q, lat_hi_d;
  byte_t       low_base_q, low_base_d;
  byte_t       high_base_q, high_base_d;
  logic        mir_q, mir_d;
  logic        chg_d;

  // output register
  logic        out_valid_q;
  byte_t       out_prg_q, out_lo_q, out_hi_q;
  logic        out_mir_q, out_chg_q;

  // remainder unit hookup
  logic        in_take;
  logic        need_div;
  logic        div_start;
  logic        div_done;
  mod_t        div_mod;
  mod_t        div_rem;
  logic [3:0]  in_nib;

  logic        out_free;
  logic [3:0]  nib;
  logic [9:0]  key;
  logic [3:0]  reg_ofs;
  logic [1:0]  reg_sel;
  byte_t       bank_val;
  logic        hit;
  logic        hit_tbl;
  logic        hit_high;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // bank writes need the remainder, decided from the live input word
  assign in_nib    = address_i[15:12];
  assign need_div  = !mode_i && (in_nib >= NIB_PRG) && (in_nib <= NIB_CHR_LAST);
  assign div_start = in_take && need_div;
  assign div_mod   = (in_nib == NIB_PRG) ? {1'b0, prg_cnt_q} : {chr_cnt_q, 1'b0};

  mmc4_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (write_data_i),
    .modulus_i  (div_mod),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // mapping update for the captured word
  assign nib     = addr_q[15:12];
  assign key     = addr_q[13:4];
  assign reg_ofs = nib - NIB_CHR_FIRST;
  assign reg_sel = reg_ofs[1:0];
  // zero modulus gives a zero bank
  assign bank_val = (chr_cnt_q == '0) ? '0 : {div_rem[DataW-3:0], 2'b00};

  assign hit      = (key == KEY_T0_LOW) || (key == KEY_T0_HIGH) ||
                    (key == KEY_T1_LOW) || (key == KEY_T1_HIGH);
  assign hit_tbl  = (key == KEY_T1_LOW) || (key == KEY_T1_HIGH);
  assign hit_high = (key == KEY_T0_HIGH) || (key == KEY_T1_HIGH);

  always_comb begin
    prg_base_d  = prg_base_q;
    chr_bank_d  = chr_bank_q;
    lat_hi_d    = lat_hi_q;
    low_base_d  = low_base_q;
    high_base_d = high_base_q;
    mir_d       = mir_q;
    chg_d       = 1'b0;
    if (!mode_q) begin
      case (nib) inside
        NIB_PRG: begin
          prg_base_d = (prg_cnt_q == '0) ? '0 : {div_rem[DataW-2:0], 1'b0};
        end
        [NIB_CHR_FIRST:NIB_CHR_LAST]: begin
          chr_bank_d[reg_sel] = bank_val;
          // live at once when this table's latch points at the register
          if (lat_hi_q[reg_sel[1]] == reg_sel[0]) begin
            if (reg_sel[1]) begin
              chg_d       = (high_base_q != bank_val);
              high_base_d = bank_val;
            end else begin
              chg_d      = (low_base_q != bank_val);
              low_base_d = bank_val;
            end
          end
        end
        NIB_MIR: begin
          mir_d = ~data_q[0];
        end
        default: ;
      endcase
    end else if (hit) begin
      lat_hi_d[hit_tbl] = hit_high;
      if (hit_tbl) begin
        chg_d       = (high_base_q != chr_bank_q[{1'b1, hit_high}]);
        high_base_d = chr_bank_q[{1'b1, hit_high}];
      end else begin
        chg_d      = (low_base_q != chr_bank_q[{1'b0, hit_high}]);
        low_base_d = chr_bank_q[{1'b0, hit_high}];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = need_div ? ST_CALC : ST_FINISH;
        end
      end
      ST_CALC: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prg_cnt_q   <= 8'd1;
      chr_cnt_q   <= '0;
      prg_base_q  <= '0;
      chr_bank_q  <= '{default: '0};
      lat_hi_q    <= 2'b11;
      low_base_q  <= '0;
      high_base_q <= HIGH_BASE_RST;
      mir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_PRG_COUNT) begin
          prg_cnt_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_CHR_COUNT) begin
          chr_cnt_q <= cfg_data_i;
        end
      end
      if (state_q == ST_FINISH && out_free) begin
        prg_base_q  <= prg_base_d;
        chr_bank_q  <= chr_bank_d;
        lat_hi_q    <= lat_hi_d;
        low_base_q  <= low_base_d;
        high_base_q <= high_base_d;
        mir_q       <= mir_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_prg_q <= prg_base_d;
      out_lo_q  <= low_base_d;
      out_hi_q  <= high_base_d;
      out_mir_q <= mir_d;
      out_chg_q <= chg_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prg_page_o      = out_prg_q;
  assign chr_low_page_o  = out_lo_q;
  assign chr_high_page_o = out_hi_q;
  assign mirror_select_o = out_mir_q;
  assign chr_changed_o   = out_chg_q;

  a_calc_ends_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && !div_done |=> state_q == ST_CALC)
    else $error("left remainder wait before the unit finished");

  a_done_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_CALC)
    else $error("remainder finished outside the wait state");

  a_word_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result word without a finished input word");

endmodule

// ===== verif/mmc4_mapping_checker.sv =====
module mmc4_mapping_checker
  import mmc4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [15:0]        address_i,
  input  byte_t              write_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  byte_t              prg_page_i,
  input  byte_t              chr_low_page_i,
  input  byte_t              chr_high_page_i,
  input  logic               mirror_select_i,
  input  logic               chr_changed_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  byte_t              cfg_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam logic MODE_CPU = 1'b0;

  typedef struct packed {
    byte_t prg_page;
    byte_t chr_low_page;
    byte_t chr_high_page;
    logic  mirror_select;
    logic  chr_changed;
  } mapping_t;

  // mapper state as the bus should see it
  byte_t    prg_units;
  byte_t    chr_units;
  byte_t    prg_base;
  byte_t    chr_banks [4];
  logic     latch_high [2];
  byte_t    low_base;
  byte_t    high_base;
  logic     mirror;
  logic     map_changed;
  mapping_t expected_maps [$];
  int       words_seen;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d %s: got %0d, want %0d", words_seen, name, got, want));
    end
  endtask

  task automatic apply_bank(input logic table_sel, input byte_t value);
    if (table_sel == 1'b0) begin
      if (low_base != value) map_changed = 1'b1;
      low_base = value;
    end else begin
      if (high_base != value) map_changed = 1'b1;
      high_base = value;
    end
  endtask

  task automatic predict_mapping(input logic mode, input logic [15:0] addr, input byte_t data,
                                 output mapping_t m);
    logic [3:0]  nib;
    logic [1:0]  bank_idx;
    logic        table_sel;
    logic        want_high;
    int unsigned modulus;
    byte_t       bank;
    map_changed = 1'b0;
    nib = addr[15:12];
    if (mode == MODE_CPU) begin
      if (nib == NIB_PRG) begin
        modulus  = prg_units;
        prg_base = (modulus == 0) ? '0 : byte_t'((data % modulus) << 1);
      end else if (nib >= NIB_CHR_FIRST && nib <= NIB_CHR_LAST) begin
        bank_idx = 2'(nib - NIB_CHR_FIRST);
        modulus  = 2 * chr_units;
        bank     = (modulus == 0) ? '0 : byte_t'((data % modulus) << 2);
        chr_banks[bank_idx] = bank;
        if (latch_high[bank_idx[1]] == bank_idx[0]) apply_bank(bank_idx[1], bank);
      end else if (nib == NIB_MIR) begin
        mirror = ~data[0];
      end
    end else begin
      table_sel = 1'b0;
      want_high = 1'b0;
      case (addr[13:4])
        KEY_T0_LOW: begin
          table_sel = 1'b0;
          want_high = 1'b0;
        end
        KEY_T0_HIGH: begin
          table_sel = 1'b0;
          want_high = 1'b1;
        end
        KEY_T1_LOW: begin
          table_sel = 1'b1;
          want_high = 1'b0;
        end
        KEY_T1_HIGH: begin
          table_sel = 1'b1;
          want_high = 1'b1;
        end
        default: ;
      endcase
      if (addr[13:4] inside {KEY_T0_LOW, KEY_T0_HIGH, KEY_T1_LOW, KEY_T1_HIGH}) begin
        latch_high[table_sel] = want_high;
        apply_bank(table_sel, chr_banks[{table_sel, want_high}]);
      end
    end
    m.prg_page      = prg_base;
    m.chr_low_page  = low_base;
    m.chr_high_page = high_base;
    m.mirror_select = mirror;
    m.chr_changed   = map_changed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_t want;
    if (!rst_ni) begin
      prg_units     = 8'd1;
      chr_units     = 8'd0;
      prg_base      = '0;
      chr_banks     = '{default: '0};
      latch_high    = '{default: 1'b1};
      low_base      = '0;
      high_base     = HIGH_BASE_RST;
      mirror        = 1'b0;
      words_seen    = 0;
      pending_o     = 0;
      fail_count_o  = 0;
      expected_maps.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_PRG_COUNT) prg_units = cfg_data_i;
        else if (cfg_index_i == CFG_CHR_COUNT) chr_units = cfg_data_i;
      end
      // results are matched before the new word is queued
      if (out_valid_i && !out_stall_i) begin
        if (expected_maps.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = expected_maps.pop_front();
          check_field("prg_page", prg_page_i, want.prg_page);
          check_field("chr_low_page", chr_low_page_i, want.chr_low_page);
          check_field("chr_high_page", chr_high_page_i, want.chr_high_page);
          check_field("mirror_select", mirror_select_i, want.mirror_select);
          check_field("chr_changed", chr_changed_i, want.chr_changed);
        end
        words_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_mapping(mode_i, address_i, write_data_i, want);
        expected_maps.push_back(want);
      end
      pending_o = expected_maps.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import mmc4_pkg::*;

  // bus event kinds carried on mode
  localparam logic MODE_CPU = 1'b0;
  localparam logic MODE_PPU = 1'b1;
  // an index past the register list, must be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CFG_CHR_COUNT + 1'b1;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_WORDS  = 120;
  localparam int HOLD_CYCLES  = 400;

  // every block input starts at a known value
  logic               clk_i       = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               mode        = MODE_CPU;
  logic [15:0]        address     = '0;
  byte_t              write_data  = '0;
  logic               out_stall   = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index   = CFG_PRG_COUNT;
  byte_t              cfg_data    = '0;

  logic  in_stall, out_valid, cfg_ready;
  byte_t prg_page, chr_low_page, chr_high_page;
  logic  mirror_select, chr_changed;
  int    pending, fail_count;

  // idle odds in percent for each side, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // one-shot request for a long receiver hold-off
  bit hold_req = 1'b0;

  mmc4_bank_latch_mapper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .address_i       (address),
    .write_data_i    (write_data),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .prg_page_o      (prg_page),
    .chr_low_page_o  (chr_low_page),
    .chr_high_page_o (chr_high_page),
    .mirror_select_o (mirror_select),
    .chr_changed_o   (chr_changed),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // watches all three channels, predicts the mapping and compares
  mmc4_mapping_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .address_i       (address),
    .write_data_i    (write_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .prg_page_i      (prg_page),
    .chr_low_page_i  (chr_low_page),
    .chr_high_page_i (chr_high_page),
    .mirror_select_i (mirror_select),
    .chr_changed_i   (chr_changed),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("** mmc4_bank_latch_mapper: FAILED **");
    $finish;
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    int burst;
    int hold_left;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        burst = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one bus event, maybe after an idle burst, and wait until taken
  // valid stays high when the next word follows right away
  task automatic send_word(input logic m, input logic [15:0] a, input byte_t d);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    address    <= a;
    write_data <= d;
    do @(posedge clk_i); while (in_stall);
  endtask

  // stop offering and wait for every expected word; pending is read
  // at the falling edge, away from the checker's updates
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // one register write; valid stays up when another write follows
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input byte_t value, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  // reprogram both counts with the mapper idle, sometimes poking the spare index
  task automatic set_counts(input byte_t prg_units, input byte_t chr_units);
    drain();
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CfgIdxW'($urandom_range(CFG_SPARE, 255)), byte_t'($urandom), 1'b0);
    end
    write_reg(CFG_PRG_COUNT, prg_units, 1'b0);
    write_reg(CFG_CHR_COUNT, chr_units, 1'b1);
  endtask

  // mostly meaningful traffic: bank writes and latch triggers, with
  // some random cpu writes and random fetch addresses mixed in
  task automatic random_word();
    int unsigned pick;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    a    = 16'($urandom);
    if (pick < 30) begin
      a[15:12] = 4'(NIB_CHR_FIRST + $urandom_range(0, NIB_CHR_LAST - NIB_CHR_FIRST));
      send_word(MODE_CPU, a, byte_t'($urandom));
    end else if (pick < 40) begin
      a[15:12] = NIB_PRG;
      send_word(MODE_CPU, a, byte_t'($urandom));
    end else if (pick < 48) begin
      a[15:12] = NIB_MIR;
      send_word(MODE_CPU, a, byte_t'($urandom));
    end else if (pick < 55) begin
      send_word(MODE_CPU, a, byte_t'($urandom));
    end else if (pick < 90) begin
      // trigger key with random bits outside the decode mask
      case ($urandom_range(0, 3))
        0:       a[13:4] = KEY_T0_LOW;
        1:       a[13:4] = KEY_T0_HIGH;
        2:       a[13:4] = KEY_T1_LOW;
        default: a[13:4] = KEY_T1_HIGH;
      endcase
      send_word(MODE_PPU, a, byte_t'($urandom));
    end else begin
      send_word(MODE_PPU, a, byte_t'($urandom));
    end
  endtask

  initial begin
    byte_t prg_units;
    byte_t chr_units;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed, reset counts: program count 1, no character rom
    send_word(MODE_PPU, {2'b00, KEY_T0_LOW, 4'h0}, 8'h00);   // same bank, no change
    send_word(MODE_PPU, {2'b00, KEY_T1_LOW, 4'h0}, 8'h00);   // upper table drops from 4
    send_word(MODE_CPU, {NIB_PRG, 12'h000}, 8'hFF);
    send_word(MODE_CPU, {NIB_MIR, 12'h000}, 8'h00);          // bit 0 clear
    send_word(MODE_CPU, 16'hFFFF, 8'h01);                    // bit 0 set
    send_word(MODE_CPU, {NIB_CHR_FIRST, 12'h000}, 8'hFF);    // zero character count
    send_word(MODE_CPU, {NIB_CHR_FIRST + 4'd1, 12'hFFF}, 8'hFF);
    send_word(MODE_CPU, {NIB_CHR_FIRST + 4'd2, 12'h555}, 8'hAA);
    send_word(MODE_CPU, {NIB_CHR_LAST, 12'hAAA}, 8'h55);
    send_word(MODE_CPU, 16'h0000, 8'hFF);                    // unmapped cpu nibbles
    send_word(MODE_CPU, 16'h9FFF, 8'h5A);
    send_word(MODE_PPU, 16'hFFFF, 8'hFF);                    // not a trigger
    send_word(MODE_PPU, {2'b11, KEY_T0_HIGH, 4'hF}, 8'h00);  // mask ignores outer bits
    send_word(MODE_PPU, {2'b01, KEY_T1_HIGH, 4'hA}, 8'hFF);

    // zero program count
    set_counts(8'd0, 8'd255);
    send_word(MODE_CPU, {NIB_PRG, 12'h123}, 8'd200);

    // both counts at the top
    set_counts(8'd255, 8'd255);
    send_word(MODE_CPU, {NIB_PRG, 12'h123}, 8'd254);
    send_word(MODE_CPU, {NIB_CHR_FIRST, 12'hFFF}, 8'd255);      // latch elsewhere, held
    send_word(MODE_CPU, {NIB_CHR_FIRST + 4'd1, 12'h000}, 8'd128); // applied at once
    send_word(MODE_CPU, {NIB_CHR_FIRST + 4'd2, 12'h000}, 8'd1);
    send_word(MODE_CPU, {NIB_CHR_LAST, 12'h000}, 8'd63);
    send_word(MODE_PPU, {2'b00, KEY_T1_HIGH, 4'h0}, 8'h00);
    send_word(MODE_PPU, {2'b00, KEY_T0_LOW, 4'h5}, 8'h00);

    // random phases, each under its own counts and idle mix
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        prg_units = 8'd255;
        chr_units = 8'd0;
      end else if (phase == 1) begin
        prg_units = 8'd1;
        chr_units = 8'd255;
      end else begin
        case ($urandom_range(0, 3))
          0:       prg_units = 8'd255;
          1:       prg_units = 8'd1;
          default: prg_units = byte_t'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 4))
          0:       chr_units = 8'd0;
          1:       chr_units = 8'd255;
          2:       chr_units = 8'd128;
          default: chr_units = byte_t'($urandom_range(1, 255));
        endcase
      end
      set_counts(prg_units, chr_units);

      if (phase == NUM_PHASES - 1) begin
        // closing stretch runs flat out on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       send_idle_pct = 0;
          1:       send_idle_pct = 10;
          default: send_idle_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0:       recv_idle_pct = 0;
          1:       recv_idle_pct = 10;
          default: recv_idle_pct = 40;
        endcase
      end

      repeat (PHASE_WORDS) random_word();
    end

    // let the last words out, then a short settle
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** mmc4_bank_latch_mapper: PASSED **");
    end else begin
      $display("** mmc4_bank_latch_mapper: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mmc4_pkg.sv
rtl/mmc4_mod_unit.sv
rtl/mmc4_bank_latch_mapper.sv
verif/mmc4_mapping_checker.sv
verif/tb_top.sv
